### src/gcv_pkg.sv
// Shared types and constants of the gap connector validator.
`timescale 1ns / 1ps
`default_nettype none

package gcv_pkg;

  // Connector selected by the mode register
  typedef enum logic [2:0] {
    MODE_NONE       = 3'd0,
    MODE_SPACE      = 3'd1,
    MODE_SPACE_OPT  = 3'd2,
    MODE_SPACE_MUST = 3'd3,
    MODE_INITIALS   = 3'd4,
    MODE_COMMA_LEAD = 3'd5,
    MODE_NAME       = 3'd6,
    MODE_LITERAL    = 3'd7
  } gcv_mode_e;

  // Register indexes on the configuration port (paddr[4:3])
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_LIT     = 2'd1;
  localparam logic [1:0] REG_LIT_LEN = 2'd2;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 64;

  // Byte codes the front end recognizes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_DASH0 = 8'hE2;
  localparam logic [7:0] CH_DASH1 = 8'h80;
  localparam logic [7:0] CH_DASH2 = 8'h93;

  // Queue depth between front and back
  localparam int unsigned QDEPTH = 2;

  // Classified gap item
  typedef struct packed {
    logic [7:0] gap_byte;
    logic       is_last;
    logic       gap_empty;
    logic       sep;     // single-byte separator
    logic       nl;
    logic       e2;
    logic       b80;
    logic       b93;
    logic       colon;
    logic       apos;
    logic       space;
    logic       comma;
    logic       dot;
    logic       upper;
  } gcv_cls_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic     valid;
    gcv_cls_t cls;
  } gcv_q_out_t;

endpackage

`default_nettype wire

### src/gcv_if.sv
// Handshake interfaces for gap items and verdict items.
`timescale 1ns / 1ps
`default_nettype none

interface gcv_gap_if;
  logic       valid;
  logic       ready;
  logic [7:0] gap_byte;
  logic       is_last;
  logic       gap_empty;

  modport source (output valid, gap_byte, is_last, gap_empty, input ready);
  modport sink   (input valid, gap_byte, is_last, gap_empty, output ready);
endinterface

interface gcv_res_if;
  logic valid;
  logic ready;
  logic gap_ok;

  modport source (output valid, gap_ok, input ready);
  modport sink   (input valid, gap_ok, output ready);
endinterface

`default_nettype wire

### src/gcv_front.sv
// Front end: accepts gap items and classifies the byte.
`timescale 1ns / 1ps
`default_nettype none

module gcv_front (
  gcv_gap_if.sink          gap_i,
  input  logic             full_i,
  output logic             push_o,
  output gcv_pkg::gcv_cls_t cls_o
);

  logic [7:0] b;

  assign b           = gap_i.gap_byte;
  assign gap_i.ready = !full_i;
  assign push_o      = gap_i.valid && !full_i;

  // Byte classes used by the recognizers
  always_comb begin
    cls_o.gap_byte  = b;
    cls_o.is_last   = gap_i.is_last;
    cls_o.gap_empty = gap_i.gap_empty;
    cls_o.sep       = (b == gcv_pkg::CH_TAB)   || (b == gcv_pkg::CH_SPACE) ||
                      (b == gcv_pkg::CH_DOT)   || (b == gcv_pkg::CH_DASH)  ||
                      (b == gcv_pkg::CH_SLASH) || (b == gcv_pkg::CH_COMMA) ||
                      (b == gcv_pkg::CH_SEMI)  || (b == gcv_pkg::CH_PIPE);
    cls_o.nl        = (b == gcv_pkg::CH_NL);
    cls_o.e2        = (b == gcv_pkg::CH_DASH0);
    cls_o.b80       = (b == gcv_pkg::CH_DASH1);
    cls_o.b93       = (b == gcv_pkg::CH_DASH2);
    cls_o.colon     = (b == gcv_pkg::CH_COLON);
    cls_o.apos      = (b == gcv_pkg::CH_APOS);
    cls_o.space     = (b == gcv_pkg::CH_SPACE);
    cls_o.comma     = (b == gcv_pkg::CH_COMMA);
    cls_o.dot       = (b == gcv_pkg::CH_DOT);
    cls_o.upper     = (b >= gcv_pkg::CH_A) && (b <= gcv_pkg::CH_Z);
  end

endmodule

`default_nettype wire

### src/gcv_fifo.sv
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module gcv_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gcv_pkg::gcv_cls_t  cls_i,
  input  logic               pop_i,
  output gcv_pkg::gcv_q_out_t q_o,
  output logic               full_o
);

  localparam int unsigned PW = $clog2(gcv_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(gcv_pkg::QDEPTH + 1);

  gcv_pkg::gcv_cls_t mem_q [gcv_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_pop;

  assign full_o    = (cnt_q == CW'(gcv_pkg::QDEPTH));
  assign q_o.valid = (cnt_q != '0);
  assign q_o.cls   = mem_q[rd_ptr_q];
  assign do_pop    = pop_i && q_o.valid;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push_i && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (!push_i && do_pop) cnt_q <= cnt_q - CW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cls_i;
  end

endmodule

`default_nettype wire

### src/gcv_back.sv
// Back end: connector recognizers, verdict and result register.
`timescale 1ns / 1ps
`default_nettype none

module gcv_back #(
  parameter int unsigned MAX_GAP     = 12,
  parameter int unsigned LITERAL_MAX = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcv_pkg::gcv_mode_e  mode_i,
  input  logic [63:0]         lit_bytes_i,
  input  logic [3:0]          lit_len_i,
  input  gcv_pkg::gcv_q_out_t q_i,
  output logic                pop_o,
  gcv_res_if.source           res_o
);

  localparam int unsigned BCW = $clog2(MAX_GAP + 2);
  localparam logic [BCW-1:0] GAP_LIM = BCW'(MAX_GAP);
  localparam logic [3:0]     LIT_LIM = 4'(LITERAL_MAX);

  // Recognizer phase codes
  localparam logic [2:0] MB_IDLE = 3'd0, MB_E2 = 3'd1, MB_80 = 3'd2,
                         MB_C1 = 3'd3, MB_C2 = 3'd4;
  localparam logic [1:0] CM_START = 2'd0, CM_SPACES = 2'd1, CM_DEAD = 2'd2;
  localparam logic [2:0] IN_SPACE = 3'd0, IN_LETTER = 3'd1, IN_AFTER = 3'd2,
                         IN_DOT = 3'd3, IN_DEAD = 3'd4;
  localparam logic [1:0] LT_LEAD = 2'd0, LT_TEXT = 2'd1, LT_TRAIL = 2'd2,
                         LT_DEAD = 2'd3;

  typedef struct packed {
    logic [BCW-1:0] byte_cnt;
    logic [1:0]     item_cnt;
    logic [2:0]     mb_phase;
    logic           item_dead;
    logic [1:0]     cm_phase;
    logic [3:0]     cm_cnt;
    logic [2:0]     in_phase;
    logic [1:0]     in_cnt;
    logic [1:0]     lt_phase;
    logic [3:0]     lt_idx;
  } gap_state_t;

  gap_state_t        st_q, st_d;
  gcv_pkg::gcv_cls_t c;
  logic [3:0]        len;
  logic [5:0]        lit_sel;
  logic [7:0]        lit_cur;
  logic              ends, verdict, items_ok1, items_ok0, comma_ok1, comma_ok0;
  logic              out_valid_q, out_ok_q;

  assign c       = q_i.cls;
  assign ends    = c.is_last || c.gap_empty;
  assign len     = (lit_len_i > LIT_LIM) ? LIT_LIM : lit_len_i;
  assign lit_sel = {st_q.lt_idx[2:0], 3'b000};
  assign lit_cur = lit_bytes_i[lit_sel +: 8];
  assign pop_o   = q_i.valid && (!ends || !out_valid_q || res_o.ready);

  // Next gap state for one byte
  always_comb begin
    st_d = st_q;
    if (!c.gap_empty) begin
      // separator items
      if (!st_q.item_dead) begin
        case (st_q.mb_phase)
          MB_IDLE: begin
            if (st_q.item_cnt == 2'd3) st_d.item_dead = 1'b1;
            else if (c.sep || (c.nl && mode_i == gcv_pkg::MODE_SPACE))
              st_d.item_cnt = st_q.item_cnt + 2'd1;
            else if (c.e2) st_d.mb_phase = MB_E2;
            else if (c.colon) st_d.mb_phase = MB_C1;
            else st_d.item_dead = 1'b1;
          end
          MB_E2: begin
            if (c.b80) st_d.mb_phase = MB_80;
            else st_d.item_dead = 1'b1;
          end
          MB_80: begin
            if (c.b93) begin
              st_d.mb_phase = MB_IDLE;
              st_d.item_cnt = st_q.item_cnt + 2'd1;
            end else st_d.item_dead = 1'b1;
          end
          MB_C1: begin
            if (c.colon) st_d.mb_phase = MB_C2;
            else st_d.item_dead = 1'b1;
          end
          MB_C2: begin
            if (c.apos) begin
              st_d.mb_phase = MB_IDLE;
              st_d.item_cnt = st_q.item_cnt + 2'd1;
            end else st_d.item_dead = 1'b1;
          end
          default: st_d.item_dead = 1'b1;
        endcase
      end

      // optional comma then spaces
      case (st_q.cm_phase)
        CM_START: begin
          if (c.comma) st_d.cm_phase = CM_SPACES;
          else if (c.space) begin
            st_d.cm_phase = CM_SPACES;
            st_d.cm_cnt   = 4'd1;
          end else st_d.cm_phase = CM_DEAD;
        end
        CM_SPACES: begin
          if (c.space) begin
            if (st_q.cm_cnt != 4'd15) st_d.cm_cnt = st_q.cm_cnt + 4'd1;
          end else st_d.cm_phase = CM_DEAD;
        end
        default: ;
      endcase

      // capital initials, leading comma in comma-led mode
      if (st_q.byte_cnt == '0 && mode_i == gcv_pkg::MODE_COMMA_LEAD) begin
        if (!c.comma) st_d.in_phase = IN_DEAD;
      end else begin
        case (st_q.in_phase)
          IN_SPACE: st_d.in_phase = c.space ? IN_LETTER : IN_DEAD;
          IN_LETTER: begin
            if (st_q.in_cnt != 2'd3 && c.upper) begin
              st_d.in_cnt   = st_q.in_cnt + 2'd1;
              st_d.in_phase = IN_AFTER;
            end else st_d.in_phase = IN_DEAD;
          end
          IN_AFTER: begin
            if (c.dot) st_d.in_phase = IN_DOT;
            else if (c.space) st_d.in_phase = IN_LETTER;
            else st_d.in_phase = IN_DEAD;
          end
          IN_DOT:  st_d.in_phase = c.space ? IN_LETTER : IN_DEAD;
          default: st_d.in_phase = IN_DEAD;
        endcase
      end

      // spaces, literal text, spaces
      case (st_q.lt_phase)
        LT_LEAD: begin
          if (!c.space) begin
            if (len == 4'd0 || c.gap_byte != lit_bytes_i[7:0]) st_d.lt_phase = LT_DEAD;
            else begin
              st_d.lt_idx   = 4'd1;
              st_d.lt_phase = (len <= 4'd1) ? LT_TRAIL : LT_TEXT;
            end
          end
        end
        LT_TEXT: begin
          if (st_q.lt_idx >= len || c.gap_byte != lit_cur) st_d.lt_phase = LT_DEAD;
          else begin
            st_d.lt_idx = st_q.lt_idx + 4'd1;
            if (st_q.lt_idx + 4'd1 >= len) st_d.lt_phase = LT_TRAIL;
          end
        end
        LT_TRAIL: if (!c.space) st_d.lt_phase = LT_DEAD;
        default: ;
      endcase

      if (st_q.byte_cnt <= GAP_LIM) st_d.byte_cnt = st_q.byte_cnt + BCW'(1);
    end
  end

  // Verdict over the state after this item
  assign items_ok0 = !st_d.item_dead && st_d.mb_phase == MB_IDLE;
  assign items_ok1 = items_ok0 && st_d.item_cnt != 2'd0;
  assign comma_ok0 = st_d.cm_phase != CM_DEAD && st_d.cm_cnt <= 4'd10;
  assign comma_ok1 = comma_ok0 && st_d.cm_cnt != 4'd0;

  always_comb begin
    verdict = 1'b0;
    if (st_d.byte_cnt <= GAP_LIM) begin
      unique case (mode_i)
        gcv_pkg::MODE_NONE:       verdict = st_d.byte_cnt == '0;
        gcv_pkg::MODE_SPACE,
        gcv_pkg::MODE_SPACE_MUST: verdict = items_ok1 || comma_ok1;
        gcv_pkg::MODE_SPACE_OPT:  verdict = st_d.byte_cnt == '0 || items_ok0 || comma_ok0;
        gcv_pkg::MODE_INITIALS:   verdict = st_d.in_phase == IN_LETTER;
        gcv_pkg::MODE_COMMA_LEAD:
          verdict = st_d.byte_cnt != '0 && st_d.in_phase == IN_LETTER;
        gcv_pkg::MODE_NAME:
          verdict = st_d.byte_cnt == BCW'(1) && st_d.cm_cnt == 4'd1;
        default:
          verdict = st_d.lt_phase == LT_TRAIL || (st_d.lt_phase == LT_LEAD && len == 4'd0);
      endcase
    end
  end

  // Gap state: cleared once the gap ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (pop_o) begin
      st_q <= ends ? '0 : st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && ends) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && ends) out_ok_q <= verdict;
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.gap_ok = out_ok_q;

endmodule

`default_nettype wire

### src/gap_connector_validator_top.sv
// Top level of the gap connector validator: config registers and the pipeline.
//
//  channel  dir  handshake      payload
//  gap_i    in   valid/ready    gap_byte[7:0], is_last, gap_empty
//  res_o    out  valid/ready    gap_ok
//  apb      in   psel/penable   paddr[4:0], pwdata[63:0] -> prdata[63:0]
//
// One gap item per cycle while the queue is not full; a verdict leaves after the
// item that ends the gap is accepted, passing the front queue and then the
// recognizer/result register. The rate is set by the back end, which updates all
// recognizers together for each item. Reset clears the config registers, the
// queue and all gap state. A stalled result holds the back end only on the next
// gap-ending item; the two-entry queue lets the front keep accepting meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module gap_connector_validator_top #(
  parameter int unsigned MAX_GAP     = 12,
  parameter int unsigned LITERAL_MAX = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gcv_gap_if.sink                       gap_i,
  gcv_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcv_pkg::APB_AW-1:0]    paddr,
  input  logic [gcv_pkg::APB_DW-1:0]    pwdata,
  output logic [gcv_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  gcv_pkg::gcv_mode_e  mode_q;
  logic [63:0]         lit_bytes_q;
  logic [3:0]          lit_len_q;
  logic                cfg_wr;
  logic [1:0]          reg_idx;
  logic                push, full, pop;
  gcv_pkg::gcv_cls_t   cls;
  gcv_pkg::gcv_q_out_t q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= gcv_pkg::MODE_NONE;
      lit_bytes_q <= '0;
      lit_len_q   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        gcv_pkg::REG_MODE:    mode_q      <= gcv_pkg::gcv_mode_e'(pwdata[2:0]);
        gcv_pkg::REG_LIT:     lit_bytes_q <= pwdata;
        gcv_pkg::REG_LIT_LEN: lit_len_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read-back decode
  always_comb begin
    unique case (reg_idx)
      gcv_pkg::REG_MODE:    prdata = {61'd0, mode_q};
      gcv_pkg::REG_LIT:     prdata = lit_bytes_q;
      gcv_pkg::REG_LIT_LEN: prdata = {60'd0, lit_len_q};
      default:              prdata = '0;
    endcase
  end

  gcv_front u_front (
    .gap_i  (gap_i),
    .full_i (full),
    .push_o (push),
    .cls_o  (cls)
  );

  gcv_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cls_i  (cls),
    .pop_i  (pop),
    .q_o    (q_head),
    .full_o (full)
  );

  gcv_back #(
    .MAX_GAP     (MAX_GAP),
    .LITERAL_MAX (LITERAL_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .lit_bytes_i (lit_bytes_q),
    .lit_len_i   (lit_len_q),
    .q_i         (q_head),
    .pop_o       (pop),
    .res_o       (res_o)
  );

  // A new result only follows a gap-ending item leaving the queue
  a_res_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |->
      $past(pop && (q_head.cls.is_last || q_head.cls.gap_empty)))
    else $error("result without a gap-ending item");

  // Back end never pops from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_head.valid)
    else $error("pop from empty queue");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (q_head.cls.is_last || q_head.cls.gap_empty)) |->
      (!res_o.valid || res_o.ready))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
